FILE: hw/rtl/rtpt_pkg.sv
package rtpt_pkg;

	localparam int unsigned TableEntries = 16;
	localparam int unsigned IdxW = 4;
	localparam int unsigned UidW = 64;
	localparam int unsigned BlkW = 56;
	localparam int unsigned CntW = 5;

	localparam logic [3:0] IdNone = 4'hF;
	localparam logic [14:0] IdMapMask = 15'h7FFF;

	typedef enum logic [1:0] {
		ST_FAIL    = 2'd0,
		ST_OK      = 2'd1,
		ST_PRESENT = 2'd2,
		ST_EXIT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EV_ADD    = 2'd0,
		EV_REMOVE = 2'd1,
		EV_ALL    = 2'd2,
		EV_FULL   = 2'd3
	} event_t;

	typedef enum logic {
		REG_RETRY_LIMIT = 1'b0,
		REG_EMPTY_LIMIT = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SEEN_DONE,
		S_WALK,
		S_ROUND_DONE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic scan_step;
		logic seen_commit;
		logic walk_step;
		logic round_commit;
		logic load_in;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic ev_pending;
		logic ev_last;
		logic match_found;
	} sts_t;

	typedef struct packed {
		logic [1:0]      res;
		logic [BlkW-1:0] blk;
		logic [3:0]      id;
		logic            last;
	} result_t;

	typedef struct packed {
		logic            func;
		logic [UidW-1:0] tag_uid;
		logic            read_ok;
		logic [BlkW-1:0] block_data;
		logic [CntW-1:0] round_tag_count;
	} request_t;

endpackage

FILE: hw/rtl/rtpt_if.sv
interface rtpt_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rtpt_ctrl.sv
module rtpt_ctrl
	import rtpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = in_func ? S_WALK : S_SCAN;
			S_SCAN: if (sts.idx_last || sts.match_found) state_d = S_SEEN_DONE;
			S_SEEN_DONE: state_d = S_EMIT;
			S_WALK: if (sts.idx_last) state_d = S_ROUND_DONE;
			S_ROUND_DONE: state_d = S_EMIT;
			S_EMIT: if (!sts.ev_pending || (out_ready && sts.ev_last)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_SEEN_DONE: cmd.seen_commit = 1'b1;
			S_WALK: cmd.walk_step = 1'b1;
			S_ROUND_DONE: cmd.round_commit = 1'b1;
			S_EMIT: out_valid = sts.ev_pending;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: hw/rtl/rtpt_dp.sv
module rtpt_dp
	import rtpt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  request_t req,
	input  logic     out_take,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  logic [7:0] cfg_data,
	output sts_t     sts,
	output result_t  res
);

	logic [7:0] retry_q, elim_q;
	logic [TableEntries-1:0] valid_q, seen_q;
	logic [UidW-1:0] uid_q [TableEntries];
	logic [BlkW-1:0] blk_q [TableEntries];
	status_t status_q [TableEntries];
	logic [7:0] miss_q [TableEntries];
	logic [3:0] sid_q [TableEntries];
	logic [14:0] idmap_q;
	logic [4:0] present_q;
	logic [7:0] empty_q;
	request_t req_q;
	logic [IdxW-1:0] idx_q;
	logic match_q;
	logic [IdxW-1:0] midx_q;
	// small result queue, one entry per possible event
	result_t evq_q [TableEntries];
	logic [IdxW:0] ev_wr_q;
	logic [IdxW:0] ev_rd_q;

	logic cur_match;
	logic [IdxW-1:0] free_idx;
	logic free_any;
	logic [3:0] new_id;
	logic [14:0] map_base;

	assign cur_match = valid_q[idx_q] && (uid_q[idx_q] == req_q.tag_uid);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = TableEntries-1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				free_any = 1'b1;
			end
		end
	end

	// lowest free short ID
	assign map_base = (present_q == '0) ? '0 : idmap_q;
	always_comb begin
		new_id = IdNone;
		for (int b = 14; b >= 0; b--) begin
			if (!map_base[b]) new_id = 4'(b);
		end
	end

	assign sts.idx_last = (idx_q == IdxW'(TableEntries-1));
	assign sts.match_found = cur_match;
	assign sts.ev_pending = (ev_rd_q != ev_wr_q);
	assign sts.ev_last = (ev_rd_q + 1'b1 == ev_wr_q);
	assign res = '{res: evq_q[ev_rd_q[IdxW-1:0]].res, blk: evq_q[ev_rd_q[IdxW-1:0]].blk,
		id: evq_q[ev_rd_q[IdxW-1:0]].id, last: sts.ev_last};

	// payload tables
	always_ff @(posedge clk) begin
		if (cmd.load_in) req_q <= req;
		if (cmd.seen_commit) begin
			if (match_q) begin
				if (status_q[midx_q] == ST_FAIL && req_q.read_ok)
					blk_q[midx_q] <= req_q.block_data;
			end else if (free_any) begin
				uid_q[free_idx] <= req_q.tag_uid;
				blk_q[free_idx] <= req_q.read_ok ? req_q.block_data : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= 8'd3;
			elim_q <= 8'd3;
			valid_q <= '0;
			seen_q <= '0;
			idmap_q <= '0;
			present_q <= '0;
			empty_q <= '0;
			idx_q <= '0;
			match_q <= 1'b0;
			midx_q <= '0;
			ev_wr_q <= '0;
			ev_rd_q <= '0;
			for (int i = 0; i < TableEntries; i++) begin
				status_q[i] <= ST_FAIL;
				miss_q[i] <= '0;
				sid_q[i] <= '0;
				evq_q[i] <= '0;
			end
		end else begin
			// configuration
			if (cfg_we) begin
				if (cfg_index == REG_RETRY_LIMIT) retry_q <= cfg_data;
				else elim_q <= cfg_data;
			end
			if (out_take) ev_rd_q <= ev_rd_q + 1'b1;
			if (cmd.load_in) begin
				idx_q <= '0;
				match_q <= 1'b0;
				ev_wr_q <= '0;
				ev_rd_q <= '0;
			end
			// compare one entry a cycle
			if (cmd.scan_step) begin
				if (cur_match) begin
					match_q <= 1'b1;
					midx_q <= idx_q;
				end
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.seen_commit) begin
				if (match_q) begin
					seen_q[midx_q] <= 1'b1;
					miss_q[midx_q] <= '0;
					if (status_q[midx_q] == ST_FAIL) begin
						if (req_q.read_ok) begin
							status_q[midx_q] <= ST_OK;
							evq_q[0] <= '{EV_ADD, req_q.block_data, sid_q[midx_q], 1'b0};
							ev_wr_q <= (IdxW+1)'(1);
						end
					end else begin
						status_q[midx_q] <= ST_PRESENT;
					end
				end else if (!free_any) begin
					evq_q[0] <= '{EV_FULL, {BlkW{1'b0}}, IdNone, 1'b0};
					ev_wr_q <= (IdxW+1)'(1);
				end else begin
					valid_q[free_idx] <= 1'b1;
					status_q[free_idx] <= req_q.read_ok ? ST_OK : ST_FAIL;
					miss_q[free_idx] <= '0;
					seen_q[free_idx] <= 1'b1;
					sid_q[free_idx] <= new_id;
					idmap_q <= (new_id == IdNone) ? map_base : (map_base | (15'd1 << new_id));
					present_q <= present_q + 1'b1;
					if (req_q.read_ok) begin
						evq_q[0] <= '{EV_ADD, req_q.block_data, new_id, 1'b0};
						ev_wr_q <= (IdxW+1)'(1);
					end
				end
			end
			// walk one entry a cycle
			if (cmd.walk_step) begin
				if (valid_q[idx_q] && !seen_q[idx_q]) begin
					if (status_q[idx_q] == ST_EXIT) begin
						if (miss_q[idx_q] < retry_q) begin
							miss_q[idx_q] <= miss_q[idx_q] + 1'b1;
						end else begin
							evq_q[ev_wr_q[IdxW-1:0]] <= '{EV_REMOVE, blk_q[idx_q], sid_q[idx_q],
								1'b0};
							ev_wr_q <= ev_wr_q + 1'b1;
							valid_q[idx_q] <= 1'b0;
							status_q[idx_q] <= ST_FAIL;
							miss_q[idx_q] <= '0;
							sid_q[idx_q] <= '0;
							if (sid_q[idx_q] == IdNone) idmap_q <= '0;
							else idmap_q <= idmap_q & ~(15'd1 << sid_q[idx_q]) & IdMapMask;
							if (present_q != '0) present_q <= present_q - 1'b1;
						end
					end else begin
						status_q[idx_q] <= ST_EXIT;
					end
				end
				seen_q[idx_q] <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			// empty round bookkeeping
			if (cmd.round_commit) begin
				if (req_q.round_tag_count != '0) begin
					empty_q <= '0;
				end else if (present_q != '0) begin
					if (((empty_q == 8'hFF) ? empty_q : empty_q + 1'b1) > elim_q) begin
						empty_q <= '0;
						valid_q <= '0;
						seen_q <= '0;
						present_q <= '0;
						for (int i = 0; i < TableEntries; i++) begin
							status_q[i] <= ST_FAIL;
							miss_q[i] <= '0;
						end
						if (ev_wr_q < (IdxW+1)'(TableEntries)) begin
							evq_q[ev_wr_q[IdxW-1:0]] <= '{EV_ALL, {BlkW{1'b0}}, 4'd0, 1'b0};
							ev_wr_q <= ev_wr_q + 1'b1;
						end
					end else if (empty_q != 8'hFF) begin
						empty_q <= empty_q + 1'b1;
					end
				end
			end
		end
	end

	// results never outrun the queue
	assert property (@(posedge clk) disable iff (!arst_n) ev_wr_q <= (IdxW+1)'(TableEntries))
		else $error("event queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) ev_rd_q <= ev_wr_q)
		else $error("event read passed write");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_commit |=> present_q == 5'($countones(valid_q)))
		else $error("present count out of step");

endmodule

FILE: hw/rtl/rfid_tag_presence_table_top.sv
// channel   dir  fields
// in_ch     in   func, tag_uid, read_ok, block_data, round_tag_count
// out_ch    out  event_res, event_block, event_tag_id, last
// cfg       in   cfg_we, cfg_index, cfg_data (0 retry_limit, 1 empty_round_limit)
// A seen request compares up to 16 entries, stopping at a match, then commits and emits its event, if any.
// A round-end request walks all 16 entries, does the round commit, then emits its events, if any.
// One request at a time; events leave from a queue, stalls on out hold the block.
// arst_n clears table status and counters and sets both limits to 3.
module rfid_tag_presence_table_top
	import rtpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rtpt_if.sink   in_ch,
	rtpt_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	result_t res;
	request_t req;

	assign req = in_ch.data;
	assign out_ch.data = res;

	rtpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_func(in_ch.data.func),
		.in_ready(in_ch.ready), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.sts(sts), .cmd(cmd)
	);

	rtpt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req),
		.out_take(out_ch.valid && out_ch.ready), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sts(sts), .res(res)
	);

endmodule
